[src/lfupbt_pkg.sv]
// Shared types, codes and defaults for the LFU page buffer table.
package lfupbt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TAG_BITS_DEF   = 16;
    localparam int CAP_BITS       = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_ACCESS = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PURGE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADDED       = 3'd0,
        KIND_EVICTED     = 3'd1,
        KIND_HIT         = 3'd2,
        KIND_ERROR       = 3'd3,
        KIND_REMOVED     = 3'd4,
        KIND_PURGE       = 3'd5,
        KIND_PURGE_EMPTY = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN,
        ST_DEL,
        ST_APP,
        ST_RDW,
        ST_HIT,
        ST_REMV,
        ST_REMF,
        ST_ERR,
        ST_EMPTY,
        ST_PRD,
        ST_PEM
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] tag;
        logic [3:0]  slot;
    } cmd_t;

endpackage

[src/lfu_page_buffer_table_unit.sv]
// Top level of the LFU page buffer table: front queue plus table sequencer.
//
// channel  | dir | beat
// s_*      | in  | tuser[1:0] op; tdata[15:0] page_tag, [19:16] slot_index
// m_*      | out | tuser[2:0] result_kind; tdata[15:0] tag, [19:16] slot; tlast
// cfg_*    | in  | cfg_wdata[4:0] max_pages, written when cfg_we high
//
// After the back end takes a command: add appends, or with eviction first walks for the
// minimum, then compacts over the single memory read port. Access reads then updates;
// remove reads, shifts entries down when they move, then reports; purge reports each tag.
// The two-entry command queue decouples input; the result register decouples output.
// Reset empties the table at once; stored entries are not cleared.
module lfu_page_buffer_table_unit
    import lfupbt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata,   // max_pages
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,     // page_tag[15:0], slot_index[19:16]
    input  logic [1:0]          s_tuser,     // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,     // page_tag_res[15:0], slot_index_res[19:16]
    output logic [2:0]          m_tuser,     // result_kind
    output logic                m_tlast
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    lfupbt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    lfupbt_back #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[src/lfupbt_front.sv]
// Front end: accepts input beats, decodes the op and queues commands.
module lfupbt_front
    import lfupbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t       buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       cmd_in;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = buf_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op   = op_t'(s_tuser);
        cmd_in.tag  = s_tdata[15:0];
        cmd_in.slot = s_tdata[19:16];
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/lfupbt_back.sv]
// Back end: table memory, sequencer for search/compaction/purge, result register.
module lfupbt_back
    import lfupbt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata,
    input  logic                q_valid,
    output logic                q_ready,
    input  cmd_t                q_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    localparam int AW = $clog2(SLOTS);
    localparam int OW = AW + 1;
    localparam int EW = TAG_BITS + COUNT_BITS;

    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [CAP_BITS-1:0]   cap_reg;
    logic [OW-1:0]         occ_reg, occ_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         cmp_reg, cmp_next;
    logic                  vld_reg, vld_next;
    logic [AW-1:0]         best_reg, best_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [TAG_BITS-1:0]   best_tag_reg, best_tag_next;
    op_t                   op_reg, op_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [3:0]            slot_reg, slot_next;
    logic                  evict_reg, evict_next;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [15:0] out_tag_reg;
    logic [3:0]  out_slot_reg;
    logic        out_last_reg;

    logic                  emit;
    kind_t                 e_kind;
    logic [15:0]           e_tag;
    logic [3:0]            e_slot;
    logic                  e_last;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    logic [TAG_BITS-1:0]   rd_tag;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [OW-1:0]         occ_m1;
    logic [OW-1:0]         cap_eff;
    logic                  can_emit;
    logic                  min_take;
    logic [AW-1:0]         best_sel;
    logic [COUNT_BITS-1:0] best_cnt_sel;
    logic [TAG_BITS-1:0]   best_tag_sel;
    logic                  last_rd;
    logic [AW-1:0]         del_v;
    logic [OW-1:0]         del_v1;
    logic                  del_skip;
    logic                  purge_last;
    logic                  slot_ok;

    assign rd_tag   = rd_data_reg[EW-1:COUNT_BITS];
    assign rd_cnt   = rd_data_reg[COUNT_BITS-1:0];
    assign occ_m1   = occ_reg - OW'(1);
    assign can_emit = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE);

    assign cap_eff = (cap_reg == '0) ? OW'(1) :
                     ((32'(cap_reg) > SLOTS) ? OW'(SLOTS) : OW'(cap_reg));

    // running minimum; lowest slot wins a tie
    assign min_take     = vld_reg && ((cmp_reg == '0) || (rd_cnt < best_cnt_reg));
    assign best_sel     = min_take ? cmp_reg : best_reg;
    assign best_cnt_sel = min_take ? rd_cnt : best_cnt_reg;
    assign best_tag_sel = min_take ? rd_tag : best_tag_reg;
    assign last_rd      = vld_reg && ({1'b0, cmp_reg} == occ_m1);

    assign del_v      = (state_reg == ST_MIN) ? best_sel : AW'(slot_reg);
    assign del_v1     = {1'b0, del_v} + OW'(1);
    assign del_skip   = (del_v1 >= occ_reg);
    assign purge_last = (({1'b0, addr_reg} + OW'(1)) == occ_reg);
    assign slot_ok    = (32'(q_cmd.slot) < 32'(occ_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_ADD:               state_next = (occ_reg >= cap_eff) ? ST_MIN : ST_APP;
                        OP_ACCESS, OP_REMOVE: state_next = slot_ok ? ST_RDW : ST_ERR;
                        OP_PURGE:             state_next = (occ_reg == '0) ? ST_EMPTY : ST_PRD;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MIN:
            begin
                if (last_rd)
                begin
                    state_next = del_skip ? ST_APP : ST_DEL;
                end
            end
            ST_DEL:
            begin
                if (last_rd)
                begin
                    state_next = (op_reg == OP_ADD) ? ST_APP : ST_REMF;
                end
            end
            ST_RDW:   state_next = (op_reg == OP_ACCESS) ? ST_HIT : ST_REMV;
            ST_REMV:  state_next = del_skip ? ST_REMF : ST_DEL;
            ST_PRD:   state_next = ST_PEM;
            ST_PEM:
            begin
                if (can_emit)
                begin
                    state_next = purge_last ? ST_IDLE : ST_PRD;
                end
            end
            ST_APP, ST_HIT, ST_REMF, ST_ERR, ST_EMPTY:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        occ_next      = occ_reg;
        addr_next     = addr_reg;
        cmp_next      = cmp_reg;
        vld_next      = vld_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        best_tag_next = best_tag_reg;
        op_next       = op_reg;
        tag_next      = tag_reg;
        slot_next     = slot_reg;
        evict_next    = evict_reg;
        emit          = 1'b0;
        e_kind        = KIND_ERROR;
        e_tag         = '0;
        e_slot        = slot_reg;
        e_last        = 1'b1;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = rd_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_cmd.op;
                    tag_next   = TAG_BITS'(q_cmd.tag);
                    slot_next  = q_cmd.slot;
                    evict_next = (occ_reg >= cap_eff);
                    vld_next   = 1'b0;
                    addr_next  = ((q_cmd.op == OP_ACCESS) || (q_cmd.op == OP_REMOVE)) ?
                                 AW'(q_cmd.slot) : '0;
                end
            end
            ST_MIN:
            begin
                best_next     = best_sel;
                best_cnt_next = best_cnt_sel;
                best_tag_next = best_tag_sel;
                vld_next      = 1'b1;
                cmp_next      = addr_reg;
                addr_next     = addr_reg + AW'(1);
                if (last_rd)
                begin
                    addr_next = AW'(del_v1);
                    vld_next  = 1'b0;
                    if (del_skip)
                    begin
                        occ_next = occ_m1;
                    end
                end
            end
            ST_DEL:
            begin
                // read slot i+1 one beat, write it to slot i the next
                if (vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_reg - AW'(1);
                    wr_data = rd_data_reg;
                end
                vld_next  = 1'b1;
                cmp_next  = addr_reg;
                addr_next = addr_reg + AW'(1);
                if (last_rd)
                begin
                    occ_next = occ_m1;
                    vld_next = 1'b0;
                end
            end
            ST_REMV:
            begin
                best_next     = del_v;
                best_tag_next = rd_tag;
                addr_next     = AW'(del_v1);
                vld_next      = 1'b0;
                if (del_skip)
                begin
                    occ_next = occ_m1;
                end
            end
            ST_HIT:
            begin
                if (can_emit)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg;
                    wr_data = {rd_tag, (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1)};
                    emit    = 1'b1;
                    e_kind  = KIND_HIT;
                    e_tag   = 16'(rd_tag);
                end
            end
            ST_APP:
            begin
                if (can_emit)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = occ_reg[AW-1:0];
                    wr_data  = {tag_reg, COUNT_BITS'(0)};
                    occ_next = occ_reg + OW'(1);
                    emit     = 1'b1;
                    e_kind   = evict_reg ? KIND_EVICTED : KIND_ADDED;
                    e_tag    = evict_reg ? 16'(best_tag_reg) : 16'(tag_reg);
                    e_slot   = evict_reg ? 4'(best_reg) : 4'(occ_reg);
                end
            end
            ST_REMF:
            begin
                emit   = can_emit;
                e_kind = KIND_REMOVED;
                e_tag  = 16'(best_tag_reg);
            end
            ST_ERR:
            begin
                emit   = can_emit;
                e_kind = KIND_ERROR;
            end
            ST_EMPTY:
            begin
                emit   = can_emit;
                e_kind = KIND_PURGE_EMPTY;
                e_slot = '0;
            end
            ST_PEM:
            begin
                e_kind = KIND_PURGE;
                e_tag  = 16'(rd_tag);
                e_slot = 4'(addr_reg);
                e_last = purge_last;
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (purge_last)
                    begin
                        occ_next = '0;
                    end
                    else
                    begin
                        addr_next = addr_reg + AW'(1);
                    end
                end
            end
            ST_RDW, ST_PRD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        cmp_reg      <= cmp_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        best_tag_reg <= best_tag_next;
        op_reg       <= op_next;
        tag_reg      <= tag_next;
        slot_reg     <= slot_next;
        evict_reg    <= evict_next;
        if (emit)
        begin
            out_kind_reg <= e_kind;
            out_tag_reg  <= e_tag;
            out_slot_reg <= e_slot;
            out_last_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            vld_reg       <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            vld_reg   <= vld_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'd0, out_slot_reg, out_tag_reg};
    assign m_tlast  = out_last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= SLOTS)
        else $error("occupancy above slot count");

    a_app_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APP) |-> (32'(occ_reg) < SLOTS))
        else $error("append with table full");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && (state_reg == ST_MIN || state_reg == ST_DEL))
            |-> ({1'b0, cmp_reg} < occ_reg))
        else $error("table walk past occupancy");

    a_purge_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEM && can_emit && purge_last) |=> (occ_reg == '0))
        else $error("purge left entries");

endmodule

[tb/tb_lfu_page_buffer_table_unit.sv]
// Stream testbench for the LFU page buffer table: queued driver, predicting monitor.
`timescale 1ns / 100ps

module tb_lfu_page_buffer_table_unit;
    import lfupbt_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tag;
        logic [3:0]  slot;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    lfu_page_buffer_table_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    // shadow of the table
    logic [15:0] shadow_tags [16];
    logic [15:0] shadow_uses [16];
    int          shadow_occ;
    logic [4:0]  shadow_cap;

    cmd_t    pending_cmds [$];
    result_t expected_results [$];
    int      errors = 0;
    bit      sender_hold = 1'b0;
    bit      rx_hold_on = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;

    task automatic push_result(kind_t k, logic [15:0] t, logic [3:0] s, logic l);
        result_t r;
        r.kind = k; r.tag = t; r.slot = s; r.last = l;
        expected_results.push_back(r);
    endtask

    task automatic drop_slot(int s);
        for (int i = s; i + 1 < shadow_occ; i++)
        begin
            shadow_tags[i] = shadow_tags[i+1];
            shadow_uses[i] = shadow_uses[i+1];
        end
        shadow_occ--;
    endtask

    task automatic predict_table(cmd_t c);
        int cap;
        int victim;
        logic [15:0] vtag;
        cap = shadow_cap;
        if (cap < 1) cap = 1;
        if (cap > 16) cap = 16;
        case (c.op)
            OP_ADD:
            begin
                if (shadow_occ >= cap)
                begin
                    victim = 0;
                    for (int i = 1; i < shadow_occ; i++)
                        if (shadow_uses[i] < shadow_uses[victim]) victim = i;
                    vtag = shadow_tags[victim];
                    drop_slot(victim);
                    push_result(KIND_EVICTED, vtag, victim[3:0], 1'b1);
                end
                else
                    push_result(KIND_ADDED, c.tag, shadow_occ[3:0], 1'b1);
                shadow_tags[shadow_occ] = c.tag;
                shadow_uses[shadow_occ] = '0;
                shadow_occ++;
            end
            OP_ACCESS, OP_REMOVE:
            begin
                if (c.slot >= shadow_occ)
                    push_result(KIND_ERROR, '0, c.slot, 1'b1);
                else if (c.op == OP_ACCESS)
                begin
                    if (shadow_uses[c.slot] != 16'hFFFF) shadow_uses[c.slot]++;
                    push_result(KIND_HIT, shadow_tags[c.slot], c.slot, 1'b1);
                end
                else
                begin
                    vtag = shadow_tags[c.slot];
                    drop_slot(c.slot);
                    push_result(KIND_REMOVED, vtag, c.slot, 1'b1);
                end
            end
            default:
            begin
                if (shadow_occ == 0)
                    push_result(KIND_PURGE_EMPTY, '0, '0, 1'b1);
                for (int i = 0; i < shadow_occ; i++)
                    push_result(KIND_PURGE, shadow_tags[i], i[3:0], i + 1 == shadow_occ);
                shadow_occ = 0;
            end
        endcase
    endtask

    // driver: bursts and gaps; a fresh item is chosen only once the last beat went
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_table(cmd_t'({s_tuser, s_tdata[15:0], s_tdata[19:16]}));
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !sender_hold)
                begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= {4'b0, c.slot, c.tag};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(12, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern of its own, or a long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_on)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(15, 0) < 11) || ($urandom_range(7, 0) == 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat kind=%0d tag=%h", m_tuser, m_tdata[15:0]);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (m_tuser != e.kind)
                begin
                    $error("result_kind expected %0d got %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] != e.tag)
                begin
                    $error("page_tag_res expected %h got %h", e.tag, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[19:16] != e.slot)
                begin
                    $error("slot_index_res expected %0d got %0d", e.slot, m_tdata[19:16]);
                    errors++;
                end
                if (m_tlast != e.last)
                begin
                    $error("last expected %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic queue_cmd(op_t op, logic [15:0] tag, logic [3:0] slot);
        cmd_t c;
        c.op = op; c.tag = tag; c.slot = slot;
        pending_cmds.push_back(c);
    endtask

    task automatic drain_all();
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_capacity(logic [4:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        shadow_cap = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly fills, hits and removes on valid slots, some wild ones
    task automatic queue_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 40)
                queue_cmd(OP_ADD, 16'($urandom), 4'($urandom));
            else if (r < 70)
                queue_cmd(OP_ACCESS, 16'($urandom), 4'($urandom_range(5, 0)));
            else if (r < 85)
                queue_cmd(OP_REMOVE, 16'($urandom), 4'($urandom_range(7, 0)));
            else if (r < 95)
                queue_cmd(op_t'($urandom_range(2, 1)), 16'($urandom), 4'($urandom));
            else
                queue_cmd(OP_PURGE, 16'($urandom), 4'($urandom));
        end
    endtask

    initial
    begin
        shadow_occ = 0;
        shadow_cap = CAP_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, errors, empty purge, full table with eviction
        queue_cmd(OP_PURGE, 16'hFFFF, 4'hF);
        queue_cmd(OP_ACCESS, 16'h0, 4'h0);
        queue_cmd(OP_REMOVE, 16'hFFFF, 4'hF);
        for (int i = 0; i < 16; i++)
            queue_cmd(OP_ADD, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom), 4'hF);
        queue_cmd(OP_ACCESS, 16'h0, 4'h0);
        queue_cmd(OP_ADD, 16'hA5A5, 4'h0);
        queue_cmd(OP_ACCESS, 16'h0, 4'hF);
        queue_cmd(OP_REMOVE, 16'h0, 4'h3);
        queue_cmd(OP_PURGE, 16'h0, 4'h0);
        drain_all();

        // minimum capacity, with the receiver held off while items pile up
        set_capacity(5'd1);
        rx_hold_on = 1'b1;
        queue_random(30);
        repeat (300) @(posedge clk);
        rx_hold_on = 1'b0;
        drain_all();

        // fill at 16, then lower the capacity below occupancy
        set_capacity(5'd16);
        for (int i = 0; i < 12; i++)
            queue_cmd(OP_ADD, 16'($urandom), 4'($urandom));
        queue_random(30);
        drain_all();
        set_capacity(5'd3);
        queue_random(30);
        drain_all();

        // out-of-range capacity values clamp
        set_capacity(5'd0);
        queue_random(15);
        drain_all();
        set_capacity(5'd31);
        queue_random(20);
        repeat (30) @(posedge clk);
        sender_hold = 1'b1;
        while (expected_results.size() > 0 || s_tvalid) @(posedge clk);
        sender_hold = 1'b0;
        drain_all();
        set_capacity(5'd6);
        queue_random(20);
        queue_cmd(OP_PURGE, 16'h0, 4'h0);
        drain_all();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
